>>> sv/rps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types and constants for the relay power sequencer.
// ----------------------------------------------------------------------------
package rps_pkg;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_SEQ_TICK  = 2'd0,
        OP_BUTTON    = 2'd1,
        OP_LOOP_TICK = 2'd2
    } op_t;

    // Operating mode, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_UP   = 4'b0010,
        MODE_WAIT = 4'b0100,
        MODE_DOWN = 4'b1000
    } mode_t;

    // Mode codes as seen on the result port
    localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CODE_UP   = 2'd1;
    localparam logic [1:0] MODE_CODE_WAIT = 2'd2;
    localparam logic [1:0] MODE_CODE_DOWN = 2'd3;

    // Button numbers
    localparam logic [2:0] BTN_UP      = 3'd0;
    localparam logic [2:0] BTN_RELAY0  = 3'd1;
    localparam logic [2:0] BTN_RELAY1  = 3'd2;
    localparam logic [2:0] BTN_AUX     = 3'd3;
    localparam logic [2:0] BTN_PROGRAM = 3'd4;
    localparam logic [2:0] BTN_RELAY2  = 3'd5;
    localparam logic [2:0] BTN_RELAY3  = 3'd6;
    localparam logic [2:0] BTN_DOWN    = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_WAIT_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_PROGRAM_MAX  = 2'd1;
    localparam logic [1:0] CFG_FLASH_LENGTH = 2'd2;

    // Configuration reset values
    localparam logic [7:0] WAIT_LIMIT_RESET   = 8'd120;
    localparam logic [1:0] PROGRAM_MAX_RESET  = 2'd2;
    localparam logic [7:0] FLASH_LENGTH_RESET = 8'd10;

    // LED pattern after reset: bits 0,1,3,5,7,9,11
    localparam logic [13:0] LED_RESET = 14'd2731;

    // Relay switching orders
    localparam logic [2:0] UP_ORDER [4]   = '{3'd0, 3'd1, 3'd2, 3'd3};
    localparam logic [2:0] DOWN_ORDER [5] = '{3'd3, 3'd2, 3'd4, 3'd1, 3'd0};

    // One input item
    typedef struct packed {
        op_t        op;
        logic [2:0] button;
    } item_t;

    // One result item
    typedef struct packed {
        logic [4:0]  relay;
        logic [13:0] led;
        logic [1:0]  mode;
        logic [1:0]  prog;
        logic [7:0]  payload;
        logic        changed;
    } rslt_t;

endpackage
`default_nettype wire

>>> sv/rps_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rps_in_stage
// Input register: captures one item per transfer and holds it until the
// engine consumes it.
// ----------------------------------------------------------------------------
module rps_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    opcode,
    input  wire logic [2:0]    button_index,
    input  wire logic          take,
    output logic               item_valid,
    output rps_pkg::item_t     item
);
    import rps_pkg::*;

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t item_reg;
    logic  accept;

    // Stall while a held item is not being consumed
    assign in_stall = in_valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    // Track occupancy of the input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture payload on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op     <= op_t'(opcode);
            item_reg.button <= button_index;
        end
    end

    assign item_valid = in_valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

>>> sv/rps_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rps_engine
// Sequencer state, configuration registers and the combinational update
// that applies one item to the state.
// ----------------------------------------------------------------------------
module rps_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          fire,
    input  wire rps_pkg::item_t item,
    output rps_pkg::rslt_t     rslt
);
    import rps_pkg::*;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  tick;
        logic        blink;
        logic [4:0]  relay;
        logic [1:0]  prog;
        logic [7:0]  flash;
        logic [13:0] led;
        logic        chg;
    } st_t;

    localparam st_t ST_RESET = '{
        mode:    MODE_IDLE,
        tick:    8'd0,
        blink:   1'b0,
        relay:   5'd0,
        prog:    2'd0,
        flash:   8'd0,
        led:     LED_RESET,
        chg:     1'b0
    };

    logic [7:0] wait_limit_reg;
    logic [1:0] program_max_reg;
    logic [7:0] flash_length_reg;
    st_t        st_reg;
    st_t        st_next;
    st_t        cur;

    function automatic logic [13:0] led_put(input logic [13:0] led, input logic [3:0] n,
                                            input logic v);
        logic [13:0] t;
        t    = led;
        t[n] = v;
        return t;
    endfunction

    function automatic st_t relay_put(input st_t s, input logic [2:0] r, input logic on);
        st_t  t;
        logic off;
        t   = s;
        off = !on;
        if (t.relay[r] != on)
        begin
            t.chg = 1'b1;
        end
        t.relay[r] = on;
        // Idle indicators follow the relay pattern
        if (t.mode == MODE_IDLE)
        begin
            t.led = led_put(t.led, 4'd0, t.relay[3:0] != 4'hF);
            t.led = led_put(t.led, 4'd13, t.relay != 5'd0);
        end
        case (r)
            3'd0:
            begin
                t.led = led_put(t.led, 4'd1, off);
                t.led = led_put(t.led, 4'd2, on);
            end
            3'd1:
            begin
                t.led = led_put(t.led, 4'd3, off);
                t.led = led_put(t.led, 4'd4, on);
            end
            3'd2:
            begin
                t.led = led_put(t.led, 4'd9, off);
                t.led = led_put(t.led, 4'd10, on);
            end
            3'd3:
            begin
                t.led = led_put(t.led, 4'd11, off);
                t.led = led_put(t.led, 4'd12, on);
            end
            default:
            begin
                t.led = led_put(t.led, 4'd5, off);
                t.led = led_put(t.led, 4'd6, on);
                t.led = led_put(t.led, 4'd7, off);
                t.led = led_put(t.led, 4'd8, on);
            end
        endcase
        return t;
    endfunction

    function automatic st_t relay_flip(input st_t s, input logic [2:0] r);
        return relay_put(s, r, !s.relay[r]);
    endfunction

    function automatic st_t enter_mode(input st_t s, input mode_t m);
        st_t t;
        t      = s;
        t.tick = 8'd0;
        t.mode = m;
        unique case (m)
            MODE_IDLE:
            begin
                t.led = led_put(t.led, 4'd0, t.relay[3:0] != 4'hF);
                t.led = led_put(t.led, 4'd13, t.relay != 5'd0);
            end
            MODE_UP:
            begin
                t.led = led_put(t.led, 4'd0, t.blink);
                t.led = led_put(t.led, 4'd13, 1'b1);
            end
            default:
            begin
                t.led = led_put(t.led, 4'd0, 1'b1);
                t.led = led_put(t.led, 4'd13, t.blink);
            end
        endcase
        return t;
    endfunction

    function automatic st_t seq_tick(input st_t s, input logic [7:0] wl);
        st_t        t;
        logic       found;
        logic [2:0] idx;
        t     = s;
        found = 1'b0;
        idx   = 3'd0;
        t.blink = !t.blink;
        t.tick  = t.tick + 8'd1;
        unique case (t.mode)
            MODE_UP:
            begin
                t.led = led_put(t.led, 4'd0, t.blink);
                if (!t.tick[0])
                begin
                    // Pick the first relay still off
                    for (int i = 0; i < 4; i++)
                    begin
                        if (!found && !t.relay[UP_ORDER[i]])
                        begin
                            found = 1'b1;
                            idx   = UP_ORDER[i];
                        end
                    end
                    if (found)
                    begin
                        t = relay_put(t, idx, 1'b1);
                    end
                    else
                    begin
                        t = enter_mode(t, MODE_IDLE);
                    end
                end
            end
            MODE_WAIT:
            begin
                t.led = led_put(t.led, 4'd13, t.blink);
                if (t.tick >= wl)
                begin
                    t = enter_mode(t, MODE_DOWN);
                end
            end
            MODE_DOWN:
            begin
                t.led = led_put(t.led, 4'd13, t.blink);
                if (!t.tick[0])
                begin
                    // Pick the first relay still on
                    for (int i = 0; i < 5; i++)
                    begin
                        if (!found && t.relay[DOWN_ORDER[i]])
                        begin
                            found = 1'b1;
                            idx   = DOWN_ORDER[i];
                        end
                    end
                    if (found)
                    begin
                        t = relay_put(t, idx, 1'b0);
                    end
                    else
                    begin
                        t = enter_mode(t, MODE_IDLE);
                    end
                end
            end
            default:
            begin
                t = t;
            end
        endcase
        return t;
    endfunction

    function automatic st_t press(input st_t s, input logic [2:0] b,
                                  input logic [1:0] pmax, input logic [7:0] flen);
        st_t        t;
        logic [2:0] p;
        t = s;
        p = 3'd0;
        unique case (b)
            BTN_UP:
            begin
                if (t.mode == MODE_IDLE && t.relay[3:0] != 4'hF)
                begin
                    t = enter_mode(t, MODE_UP);
                end
                else if (t.mode == MODE_WAIT || t.mode == MODE_DOWN)
                begin
                    t = enter_mode(t, MODE_IDLE);
                end
            end
            BTN_RELAY0:
            begin
                t = relay_flip(t, 3'd0);
            end
            BTN_RELAY1:
            begin
                t = relay_flip(t, 3'd1);
            end
            BTN_AUX:
            begin
                t.prog = 2'd0;
                t = relay_flip(t, 3'd4);
            end
            BTN_PROGRAM:
            begin
                if (!t.relay[4])
                begin
                    t.prog = 2'd0;
                    t = relay_put(t, 3'd4, 1'b1);
                end
                else
                begin
                    // Step the program and start the LED 7 flash
                    t.led = led_put(t.led, 4'd7, 1'b1);
                    p = {1'b0, t.prog} + 3'd1;
                    if (p > {1'b0, pmax})
                    begin
                        p = 3'd0;
                    end
                    t.prog  = p[1:0];
                    t.chg   = 1'b1;
                    t.flash = flen;
                end
            end
            BTN_RELAY2:
            begin
                t = relay_flip(t, 3'd2);
            end
            BTN_RELAY3:
            begin
                t = relay_flip(t, 3'd3);
            end
            BTN_DOWN:
            begin
                if (t.mode == MODE_IDLE && t.relay != 5'd0)
                begin
                    t = enter_mode(t, MODE_WAIT);
                end
                else if (t.mode == MODE_UP)
                begin
                    t = enter_mode(t, MODE_IDLE);
                end
                else if (t.mode == MODE_WAIT)
                begin
                    t = enter_mode(t, MODE_DOWN);
                end
            end
            default:
            begin
                t = t;
            end
        endcase
        return t;
    endfunction

    function automatic st_t loop_tick(input st_t s);
        st_t t;
        t = s;
        if (t.flash != 8'd0)
        begin
            if (t.flash == 8'd1)
            begin
                t.led = led_put(t.led, 4'd7, !t.relay[4]);
            end
            t.flash = t.flash - 8'd1;
        end
        return t;
    endfunction

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        unique case (m)
            MODE_IDLE: c = MODE_CODE_IDLE;
            MODE_UP:   c = MODE_CODE_UP;
            MODE_WAIT: c = MODE_CODE_WAIT;
            MODE_DOWN: c = MODE_CODE_DOWN;
            default:   c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

    // Hold configuration; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_limit_reg   <= WAIT_LIMIT_RESET;
            program_max_reg  <= PROGRAM_MAX_RESET;
            flash_length_reg <= FLASH_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WAIT_LIMIT:   wait_limit_reg   <= cfg_data;
                CFG_PROGRAM_MAX:  program_max_reg  <= cfg_data[1:0];
                CFG_FLASH_LENGTH: flash_length_reg <= cfg_data;
                default:          wait_limit_reg   <= wait_limit_reg;
            endcase
        end
    end

    // Apply one item to the state
    always_comb
    begin
        cur     = st_reg;
        cur.chg = 1'b0;
        unique case (item.op)
            OP_SEQ_TICK:  st_next = seq_tick(cur, wait_limit_reg);
            OP_BUTTON:    st_next = press(cur, item.button, program_max_reg,
                                          flash_length_reg);
            OP_LOOP_TICK: st_next = loop_tick(cur);
            default:      st_next = cur;
        endcase
    end

    // Advance state on each consumed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    // Assemble the result from the updated state
    always_comb
    begin
        rslt.relay   = st_next.relay;
        rslt.led     = st_next.led;
        rslt.mode    = mode_code(st_next.mode);
        rslt.prog    = st_next.prog;
        rslt.payload = {1'b0, st_next.prog, st_next.relay};
        rslt.changed = st_next.chg;
    end

endmodule
`default_nettype wire

>>> sv/rps_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rps_out_stage
// Result register: holds one result until the receiving side takes it.
// ----------------------------------------------------------------------------
module rps_out_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire rps_pkg::rslt_t  rslt,
    output logic                 load_ok,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output rps_pkg::rslt_t       rslt_out
);
    import rps_pkg::*;

    logic  out_valid_reg;
    logic  out_valid_next;
    rslt_t rslt_reg;

    // Room for a new result when empty or draining this cycle
    assign load_ok = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rslt_reg <= rslt;
        end
    end

    assign out_valid = out_valid_reg;
    assign rslt_out  = rslt_reg;

endmodule
`default_nettype wire

>>> sv/relay_power_sequencer_top.sv
// Path: an input transfer is held in the input register, then the
//   combinational state update loads its result into the result register.
// Throughput: one item per cycle while out_stall is low.
// Reset (rst_n low, asynchronous): idle mode, relays off, LED pattern 2731,
//   configuration back to 120 / 2 / 10, both pipeline stages empty.
`default_nettype none
// ----------------------------------------------------------------------------
// relay_power_sequencer_top
// Relay power sequencer: ticks and button presses drive five relays,
// fourteen indicator LEDs and a program selector.
// ----------------------------------------------------------------------------
module relay_power_sequencer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [2:0]  button_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       relay_bits,
    output logic [13:0]      led_bits,
    output logic [1:0]       current_mode,
    output logic [1:0]       program_step,
    output logic [7:0]       payload_byte,
    output logic             payload_changed,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import rps_pkg::*;

    logic  item_valid;
    item_t item;
    logic  load_ok;
    logic  fire;
    rslt_t rslt;
    rslt_t rslt_out;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    // Consume the held item when the result register has room
    assign fire = item_valid && load_ok;

    rps_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .button_index (button_index),
        .take         (fire),
        .item_valid   (item_valid),
        .item         (item)
    );

    rps_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .rslt      (rslt)
    );

    rps_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .rslt      (rslt),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rslt_out  (rslt_out)
    );

    // Drive result fields
    assign relay_bits      = rslt_out.relay;
    assign led_bits        = rslt_out.led;
    assign current_mode    = rslt_out.mode;
    assign program_step    = rslt_out.prog;
    assign payload_byte    = rslt_out.payload;
    assign payload_changed = rslt_out.changed;

endmodule
`default_nettype wire
